### hw/rtl/v4n_pkg.sv
// Package with the shared constants of the four-component vector normalizer.
`default_nettype none
package v4n_pkg;
	localparam int COMP_BITS_DEF = 16;
	localparam int UNIT_BITS     = 16;
	localparam int QUOT_BITS     = 15;
	localparam logic [QUOT_BITS-1:0] UNIT_ONE = QUOT_BITS'(16384);
	localparam int NUM_COMP      = 4;
endpackage
`default_nettype wire

### hw/rtl/v4n_in_if.sv
// Input channel interface carrying one four-component vector per transaction.
`default_nettype none
interface v4n_in_if #(parameter int COMPONENT_BITS = 16);
	logic                             valid;
	logic                             ready;
	logic signed [COMPONENT_BITS-1:0] comp_x;
	logic signed [COMPONENT_BITS-1:0] comp_y;
	logic signed [COMPONENT_BITS-1:0] comp_z;
	logic signed [COMPONENT_BITS-1:0] comp_w;
	modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
	modport sink (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface
`default_nettype wire

### hw/rtl/v4n_out_if.sv
// Output channel interface carrying one normalized vector per transaction.
`default_nettype none
interface v4n_out_if #(parameter int COMPONENT_BITS = 16);
	logic                      valid;
	logic                      ready;
	logic signed [15:0]        unit_x;
	logic signed [15:0]        unit_y;
	logic signed [15:0]        unit_z;
	logic signed [15:0]        unit_w;
	logic [COMPONENT_BITS:0]   length;
	logic                      zero_vector;
	modport source (output valid, unit_x, unit_y, unit_z, unit_w, length, zero_vector,
		input ready);
	modport sink (input valid, unit_x, unit_y, unit_z, unit_w, length, zero_vector,
		output ready);
endinterface
`default_nettype wire

### hw/rtl/vector4_normalize.sv
// Top level of the pipelined four-component vector normalizer.
`default_nettype none
// The block accepts one vector per cycle while the output is not stalled and returns one
// result per vector, in order. Three stages form the magnitudes, their squares and the
// sum, COMPONENT_BITS + 1 stages each settle one bit of the square root, fifteen stages
// each settle one quotient bit of the four divisions, and an output register holds the
// result. When the output is stalled the whole pipeline holds.
module vector4_normalize import v4n_pkg::*; #(
	parameter int COMPONENT_BITS = COMP_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	v4n_in_if.sink    vec_in,
	v4n_out_if.source vec_out
);
	localparam int N     = COMPONENT_BITS;
	localparam int RB    = N + 1;
	localparam int RW    = 2 * RB;
	localparam int REM_W = RB + 2;
	localparam int DIV_W = N + 2;

	logic adv;
	logic vld_out_q;

	logic [N-1:0]   in_v [NUM_COMP];
	logic           vld_s1, vld_s2, vld_s3;
	logic [N-1:0]   mag_s1 [NUM_COMP];
	logic           neg_s1 [NUM_COMP];
	logic [N-1:0]   mag_s2 [NUM_COMP];
	logic           neg_s2 [NUM_COMP];
	logic [2*N-1:0] sq_s2  [NUM_COMP];
	logic [N-1:0]   mag_s3 [NUM_COMP];
	logic           neg_s3 [NUM_COMP];
	logic [RW-1:0]  sum_s3;

	logic             vld_rt_s [RB+1];
	logic [RW-1:0]    rad_rt_s [RB+1];
	logic [REM_W-1:0] rem_rt_s [RB+1];
	logic [RB-1:0]    root_rt_s [RB+1];
	logic [N-1:0]     mag_rt_s [RB+1][NUM_COMP];
	logic             neg_rt_s [RB+1][NUM_COMP];

	logic                 vld_dv_s [QUOT_BITS+1];
	logic [RB-1:0]        len_dv_s [QUOT_BITS+1];
	logic [DIV_W-1:0]     dr_dv_s  [QUOT_BITS+1][NUM_COMP];
	logic [QUOT_BITS-1:0] q_dv_s   [QUOT_BITS+1][NUM_COMP];
	logic                 neg_dv_s [QUOT_BITS+1][NUM_COMP];

	logic [UNIT_BITS-1:0] unit_q [NUM_COMP];
	logic [RB-1:0]        len_q;
	logic                 zero_q;

	assign adv          = !vld_out_q || vec_out.ready;
	assign vec_in.ready = adv;
	assign in_v[0]      = vec_in.comp_x;
	assign in_v[1]      = vec_in.comp_y;
	assign in_v[2]      = vec_in.comp_z;
	assign in_v[3]      = vec_in.comp_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vec_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NUM_COMP; i++) begin
				neg_s1[i] <= in_v[i][N-1];
				mag_s1[i] <= in_v[i][N-1] ? N'(-in_v[i]) : in_v[i];
				mag_s2[i] <= mag_s1[i];
				neg_s2[i] <= neg_s1[i];
				sq_s2[i]  <= mag_s1[i] * mag_s1[i];
				mag_s3[i] <= mag_s2[i];
				neg_s3[i] <= neg_s2[i];
			end
			sum_s3 <= RW'(sq_s2[0]) + RW'(sq_s2[1]) + RW'(sq_s2[2]) + RW'(sq_s2[3]);
		end
	end

	assign vld_rt_s[0]  = vld_s3;
	assign rad_rt_s[0]  = sum_s3;
	assign rem_rt_s[0]  = '0;
	assign root_rt_s[0] = '0;
	for (genvar c = 0; c < NUM_COMP; c++) begin : g_rt_in
		assign mag_rt_s[0][c] = mag_s3[c];
		assign neg_rt_s[0][c] = neg_s3[c];
	end

	for (genvar k = 0; k < RB; k++) begin : g_root
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		logic             take;
		assign rem_sh = {rem_rt_s[k][REM_W-3:0], rad_rt_s[k][RW-1:RW-2]};
		assign trial  = {root_rt_s[k], 2'b01};
		assign take   = rem_sh >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_rt_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_rt_s[k+1] <= vld_rt_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rad_rt_s[k+1]  <= {rad_rt_s[k][RW-3:0], 2'b00};
				rem_rt_s[k+1]  <= take ? rem_sh - trial : rem_sh;
				root_rt_s[k+1] <= {root_rt_s[k][RB-2:0], take};
				for (int i = 0; i < NUM_COMP; i++) begin
					mag_rt_s[k+1][i] <= mag_rt_s[k][i];
					neg_rt_s[k+1][i] <= neg_rt_s[k][i];
				end
			end
		end
	end

	assign vld_dv_s[0] = vld_rt_s[RB];
	assign len_dv_s[0] = root_rt_s[RB];
	for (genvar c = 0; c < NUM_COMP; c++) begin : g_dv_in
		assign dr_dv_s[0][c]  = DIV_W'(mag_rt_s[RB][c]);
		assign q_dv_s[0][c]   = '0;
		assign neg_dv_s[0][c] = neg_rt_s[RB][c];
	end

	for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
		logic             ge   [NUM_COMP];
		logic [DIV_W-1:0] diff [NUM_COMP];
		for (genvar c = 0; c < NUM_COMP; c++) begin : g_c
			assign ge[c]   = dr_dv_s[j][c] >= DIV_W'(len_dv_s[j]);
			assign diff[c] = ge[c] ? dr_dv_s[j][c] - DIV_W'(len_dv_s[j]) : dr_dv_s[j][c];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv_s[j+1] <= 1'b0;
			end else if (adv) begin
				vld_dv_s[j+1] <= vld_dv_s[j];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				len_dv_s[j+1] <= len_dv_s[j];
				for (int i = 0; i < NUM_COMP; i++) begin
					dr_dv_s[j+1][i]  <= {diff[i][DIV_W-2:0], 1'b0};
					q_dv_s[j+1][i]   <= {q_dv_s[j][i][QUOT_BITS-2:0], ge[i]};
					neg_dv_s[j+1][i] <= neg_dv_s[j][i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q <= 1'b0;
		end else if (adv) begin
			vld_out_q <= vld_dv_s[QUOT_BITS];
		end
	end

	always_ff @(posedge clk) begin
		logic [QUOT_BITS-1:0] qs;
		if (adv) begin
			len_q  <= len_dv_s[QUOT_BITS];
			zero_q <= len_dv_s[QUOT_BITS] == '0;
			for (int i = 0; i < NUM_COMP; i++) begin
				qs = (q_dv_s[QUOT_BITS][i] > UNIT_ONE) ? UNIT_ONE : q_dv_s[QUOT_BITS][i];
				if (len_dv_s[QUOT_BITS] == '0) begin
					unit_q[i] <= '0;
				end else if (neg_dv_s[QUOT_BITS][i]) begin
					unit_q[i] <= UNIT_BITS'(-{1'b0, qs});
				end else begin
					unit_q[i] <= UNIT_BITS'(qs);
				end
			end
		end
	end

	assign vec_out.valid       = vld_out_q;
	assign vec_out.unit_x      = unit_q[0];
	assign vec_out.unit_y      = unit_q[1];
	assign vec_out.unit_z      = unit_q[2];
	assign vec_out.unit_w      = unit_q[3];
	assign vec_out.length      = len_q;
	assign vec_out.zero_vector = zero_q;
endmodule
`default_nettype wire
